### rtl/fwbp_pkg.sv
// Package with the sizes, codes and request/result types of the write-back buffer pool.
package fwbp_pkg;

    localparam int ENTRIES    = 2;
    localparam int ID_WIDTH   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;

    localparam logic [1:0] KIND_LOAD      = 2'd0;
    localparam logic [1:0] KIND_FETCH     = 2'd1;
    localparam logic [1:0] KIND_WRITEBACK = 2'd2;
    localparam logic [1:0] KIND_ACK       = 2'd3;

    typedef struct packed {
        logic [1:0]            cmd;
        logic                  is_data;
        logic [ID_WIDTH-1:0]   record_id;
        logic [WORD_WIDTH-1:0] content;
    } t_in_item;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  out_is_data;
        logic [ID_WIDTH-1:0]   out_record_id;
        logic [WORD_WIDTH-1:0] out_content;
        logic                  last;
    } t_out_item;

    typedef logic [1:0] t_res_cnt;

endpackage

### rtl/fwbp_core.sv
// Slot store, tag compare, FIFO replacement and result forming for one request.
module fwbp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  fwbp_pkg::t_in_item  i_req,
    output fwbp_pkg::t_out_item o_res0,
    output fwbp_pkg::t_out_item o_res1,
    output fwbp_pkg::t_res_cnt  o_res_cnt
);

    logic [fwbp_pkg::ENTRIES-1:0]    r_valid;
    logic [fwbp_pkg::ENTRIES-1:0]    r_dirty;
    logic [fwbp_pkg::ENTRIES-1:0]    r_is_data;
    logic [fwbp_pkg::ID_WIDTH-1:0]   r_rec  [fwbp_pkg::ENTRIES];
    logic [fwbp_pkg::WORD_WIDTH-1:0] r_word [fwbp_pkg::ENTRIES];
    logic [fwbp_pkg::SLOT_W-1:0]     r_oldest;
    logic [fwbp_pkg::CNT_W-1:0]      r_count;
    logic                            r_pend;
    logic                            r_pend_d;
    logic [fwbp_pkg::ID_WIDTH-1:0]   r_pend_id;

    logic [fwbp_pkg::SLOT_W-1:0]     n_oldest;
    logic [fwbp_pkg::CNT_W-1:0]      n_count;

    logic                            key_d;
    logic [fwbp_pkg::ID_WIDTH-1:0]   key_id;
    logic [fwbp_pkg::ENTRIES-1:0]    hit_vec;
    logic [fwbp_pkg::ENTRIES-1:0]    old_vec;
    logic [fwbp_pkg::ENTRIES-1:0]    ins_vec;
    logic                            hit;
    logic [fwbp_pkg::WORD_WIDTH-1:0] hit_word;
    logic [fwbp_pkg::WORD_WIDTH-1:0] ev_word;
    logic [fwbp_pkg::ID_WIDTH-1:0]   ev_id;
    logic                            ev_d;
    logic                            ev_dirty;
    logic                            full;
    logic                            is_load;
    logic                            is_upd;
    logic                            is_fill;
    logic                            has_main;
    logic                            do_evict;
    logic                            do_install;
    logic                            wb;
    logic [fwbp_pkg::SUM_W-1:0]      pos_sum;
    logic [fwbp_pkg::SLOT_W-1:0]     ins_pos;
    logic [fwbp_pkg::SLOT_W-1:0]     oldest_inc;
    fwbp_pkg::t_out_item             main_item;
    fwbp_pkg::t_out_item             wb_item;

    always_comb begin
        is_load = (i_req.cmd == fwbp_pkg::CMD_LOAD);
        is_upd  = (i_req.cmd == fwbp_pkg::CMD_UPDATE);
        is_fill = (i_req.cmd == fwbp_pkg::CMD_FILL) && r_pend;
        key_d   = (i_req.cmd == fwbp_pkg::CMD_FILL) ? r_pend_d : i_req.is_data;
        key_id  = (i_req.cmd == fwbp_pkg::CMD_FILL) ? r_pend_id : i_req.record_id;

        hit_word = '0;
        ev_word  = '0;
        ev_id    = '0;
        ev_d     = 1'b0;
        ev_dirty = 1'b0;
        for (int i = 0; i < fwbp_pkg::ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_is_data[i] == key_d) && (r_rec[i] == key_id);
            old_vec[i] = (r_oldest == fwbp_pkg::SLOT_W'(i));
            hit_word   = hit_word | ({fwbp_pkg::WORD_WIDTH{hit_vec[i]}} & r_word[i]);
            ev_word    = ev_word | ({fwbp_pkg::WORD_WIDTH{old_vec[i]}} & r_word[i]);
            ev_id      = ev_id | ({fwbp_pkg::ID_WIDTH{old_vec[i]}} & r_rec[i]);
            ev_d       = ev_d | (old_vec[i] & r_is_data[i]);
            ev_dirty   = ev_dirty | (old_vec[i] & r_dirty[i]);
        end
        hit = |hit_vec;

        full       = (r_count == fwbp_pkg::CNT_W'(fwbp_pkg::ENTRIES));
        has_main   = is_load || is_upd || is_fill;
        do_evict   = has_main && !hit && full;
        do_install = (is_upd || is_fill) && !hit;
        wb         = do_evict && ev_dirty;

        pos_sum = fwbp_pkg::SUM_W'(r_oldest) + fwbp_pkg::SUM_W'(r_count);
        if (pos_sum >= fwbp_pkg::SUM_W'(fwbp_pkg::ENTRIES)) begin
            pos_sum = pos_sum - fwbp_pkg::SUM_W'(fwbp_pkg::ENTRIES);
        end
        ins_pos = full ? r_oldest : pos_sum[fwbp_pkg::SLOT_W-1:0];
        for (int i = 0; i < fwbp_pkg::ENTRIES; i++) begin
            ins_vec[i] = (ins_pos == fwbp_pkg::SLOT_W'(i));
        end

        oldest_inc = (r_oldest == fwbp_pkg::SLOT_W'(fwbp_pkg::ENTRIES - 1)) ?
                     '0 : r_oldest + 1'b1;
        n_oldest   = do_evict ? oldest_inc : r_oldest;
        n_count    = r_count;
        if (do_evict && !do_install) begin
            n_count = r_count - 1'b1;
        end else if (!do_evict && do_install) begin
            n_count = r_count + 1'b1;
        end

        main_item.out_is_data   = key_d;
        main_item.out_record_id = key_id;
        main_item.last          = 1'b1;
        if (is_upd) begin
            main_item.kind        = fwbp_pkg::KIND_ACK;
            main_item.out_content = i_req.content;
        end else if (is_fill) begin
            main_item.kind        = fwbp_pkg::KIND_LOAD;
            main_item.out_content = hit ? hit_word : i_req.content;
        end else begin
            main_item.kind        = hit ? fwbp_pkg::KIND_LOAD : fwbp_pkg::KIND_FETCH;
            main_item.out_content = hit ? hit_word : '0;
        end

        wb_item.kind          = fwbp_pkg::KIND_WRITEBACK;
        wb_item.out_is_data   = ev_d;
        wb_item.out_record_id = ev_id;
        wb_item.out_content   = ev_word;
        wb_item.last          = 1'b0;

        o_res0    = wb ? wb_item : main_item;
        o_res1    = main_item;
        o_res_cnt = fwbp_pkg::t_res_cnt'({1'b0, wb}) + fwbp_pkg::t_res_cnt'({1'b0, has_main});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_dirty   <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_pend_d  <= 1'b0;
            r_pend_id <= '0;
        end else if (i_fire) begin
            r_oldest <= n_oldest;
            r_count  <= n_count;
            if (is_load && !hit) begin
                r_pend    <= 1'b1;
                r_pend_d  <= i_req.is_data;
                r_pend_id <= i_req.record_id;
            end else if (is_fill) begin
                r_pend <= 1'b0;
            end
            for (int i = 0; i < fwbp_pkg::ENTRIES; i++) begin
                if (do_install && ins_vec[i]) begin
                    r_valid[i] <= 1'b1;
                    r_dirty[i] <= is_upd;
                end else if (do_evict && old_vec[i]) begin
                    r_valid[i] <= 1'b0;
                    r_dirty[i] <= 1'b0;
                end else if (is_upd && hit_vec[i]) begin
                    r_dirty[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            for (int i = 0; i < fwbp_pkg::ENTRIES; i++) begin
                if (do_install && ins_vec[i]) begin
                    r_is_data[i] <= key_d;
                    r_rec[i]     <= key_id;
                    r_word[i]    <= i_req.content;
                end else if (is_upd && hit_vec[i]) begin
                    r_word[i] <= i_req.content;
                end
            end
        end
    end

endmodule

### rtl/fwbp_obuf.sv
// Two-entry result register that hands the results of one request out in order.
module fwbp_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  fwbp_pkg::t_res_cnt  i_push_cnt,
    input  fwbp_pkg::t_out_item i_item0,
    input  fwbp_pkg::t_out_item i_item1,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output fwbp_pkg::t_out_item o_out_data,
    output logic                o_can_take
);

    fwbp_pkg::t_res_cnt  r_cnt;
    fwbp_pkg::t_res_cnt  n_cnt;
    fwbp_pkg::t_out_item r_q0;
    fwbp_pkg::t_out_item r_q1;
    logic                pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q0;
    assign pop         = o_out_valid && i_out_ready;
    assign o_can_take  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);

    always_comb begin
        if (i_push) begin
            n_cnt = i_push_cnt;
        end else if (pop) begin
            n_cnt = r_cnt - 1'b1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q0 <= i_item0;
            r_q1 <= i_item1;
        end else if (pop) begin
            r_q0 <= r_q1;
        end
    end

endmodule

### rtl/fifo_writeback_buffer_pool.sv
// Top level of the write-back buffer pool: request register, slot core and result buffer.
//
// Requests enter on i_in_valid/o_in_ready with i_in_data (load, update or fill).
// Results leave on o_out_valid/i_out_ready with o_out_data; each request gives
// zero, one or two results, the last of them flagged by the last field.
// A request is held in the request register, then looked up against all
// slots at once and the slot state is updated in that same cycle, and its
// results land in a two-entry result register. The first result is offered
// from that result register, so it comes after both the request register and the lookup.
// One request is taken per cycle as long as each gives at most one result and
// the receiver keeps up; a request with a write-back ahead of its main result
// holds the next request while the second result drains.
// Reset empties every slot, clears the dirty bits, the pending fetch and the
// replacement pointer. When the receiver stalls, results stay in the result
// register, the held request waits, and o_in_ready stays low while the request
// register holds a request that cannot yet go on.
module fifo_writeback_buffer_pool (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fwbp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fwbp_pkg::t_out_item o_out_data
);

    logic                r_in_valid;
    fwbp_pkg::t_in_item  r_in;
    logic                fire;
    logic                can_take;
    fwbp_pkg::t_out_item res0;
    fwbp_pkg::t_out_item res1;
    fwbp_pkg::t_res_cnt  res_cnt;

    assign fire       = r_in_valid && can_take;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    fwbp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_req     (r_in),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_res_cnt (res_cnt)
    );

    fwbp_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fire),
        .i_push_cnt  (res_cnt),
        .i_item0     (res0),
        .i_item1     (res1),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_can_take  (can_take)
    );

`ifndef SYNTHESIS
    a_two_results_lead_with_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (res_cnt == 2'd2)) |->
            ((res0.kind == fwbp_pkg::KIND_WRITEBACK) && !res0.last && res1.last))
        else $error("two results without a leading write-back");

    a_single_result_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (res_cnt == 2'd1)) |-> (res0.last && (res0.kind != fwbp_pkg::KIND_WRITEBACK)))
        else $error("single result is not a final main result");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result offered right after reset");
`endif

endmodule
